FILE: rtl/dit_pkg.sv
// Package: shared types and constants of the dependency invalidation table.
package dit_pkg;

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_INVAL  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD,
    ST_CMP,
    ST_SUM
  } state_t;

  localparam int KEY_W = 32;
  localparam int HND_W = 16;
  localparam int CNT_W = 5;
  localparam logic [CNT_W-1:0] COUNT_MAX = 5'd31;

  typedef struct packed {
    logic [1:0]       mode;
    logic [KEY_W-1:0] key_token;
    logic [HND_W-1:0] handle;
  } in_t;

  typedef struct packed {
    logic [HND_W-1:0] stale_handle;
    logic             stale_valid;
    logic [CNT_W-1:0] match_count;
    logic             status;
    logic             last;
  } out_t;

  typedef struct packed {
    logic valid;
    out_t data;
  } res_req_t;

endpackage

FILE: rtl/dependency_invalidation_table.sv
// Add or unused mode: the summary state follows the transfer, then the output register.
// Remove-all and invalidate: RAM read and compare/swap per occupied slot, then summary.
// A new item is taken only once the summary has been taken; output stalls hold the scan.
// One RAM with two read ports holds the table; the scan shares one compare unit.
// Reset clears occupancy and the sequencer; table contents stay undefined, no clear pass.
module dependency_invalidation_table #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  dit_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output dit_pkg::out_t out_data
);

  logic              busy, take, start;
  dit_pkg::res_req_t req;
  logic              out_valid_r;
  dit_pkg::out_t     out_data_r;

  assign in_stall  = busy;
  assign start     = in_valid && !busy;
  assign take      = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  dit_scan #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .item  (in_data),
    .busy  (busy),
    .req   (req),
    .take  (take)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (req.valid && take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (req.valid && take) begin
      out_data_r <= req.data;
    end
  end

endmodule

FILE: rtl/dit_ram.sv
// Generic RAM: one write port, two registered read ports.
module dit_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

FILE: rtl/dit_scan.sv
// Scan sequencer: table storage, slot compare unit and swap-last deletion.
module dit_scan #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  dit_pkg::in_t      item,
  output logic              busy,
  output dit_pkg::res_req_t req,
  input  logic              take
);

  localparam int OCC_W = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int ENT_W = dit_pkg::KEY_W + dit_pkg::HND_W;

  dit_pkg::state_t state_r, state_nxt;
  logic [1:0]               mode_r, mode_nxt;
  logic [dit_pkg::KEY_W-1:0] key_r, key_nxt;
  logic [dit_pkg::HND_W-1:0] hnd_r, hnd_nxt;
  logic [OCC_W-1:0]         occ_r, occ_nxt;
  logic [IDX_W-1:0]         idx_r, idx_nxt;
  logic [dit_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                     status_r, status_nxt;

  logic             we, re;
  logic [IDX_W-1:0] waddr, last_idx;
  logic [ENT_W-1:0] wdata, rdata_a, rdata_b;
  logic             match, emit;
  logic [dit_pkg::KEY_W-1:0] rd_key;
  logic [dit_pkg::HND_W-1:0] rd_hnd;
  logic [dit_pkg::CNT_W-1:0] cnt_inc;

  assign last_idx = IDX_W'(occ_r - OCC_W'(1));
  assign rd_key   = rdata_a[ENT_W-1 -: dit_pkg::KEY_W];
  assign rd_hnd   = rdata_a[dit_pkg::HND_W-1:0];
  assign match    = (mode_r == dit_pkg::MODE_REMOVE) ? (rd_hnd == hnd_r) : (rd_key == key_r);
  assign emit     = (mode_r == dit_pkg::MODE_INVAL) && match && (rd_hnd != '0);
  assign cnt_inc  = (cnt_r == dit_pkg::COUNT_MAX) ? cnt_r : cnt_r + dit_pkg::CNT_W'(1);
  assign busy     = (state_r != dit_pkg::ST_IDLE);

  dit_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .re      (re),
    .raddr_a (idx_r),
    .raddr_b (last_idx),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dit_pkg::ST_IDLE;
      occ_r   <= '0;
    end else begin
      state_r <= state_nxt;
      occ_r   <= occ_nxt;
    end
    mode_r   <= mode_nxt;
    key_r    <= key_nxt;
    hnd_r    <= hnd_nxt;
    idx_r    <= idx_nxt;
    cnt_r    <= cnt_nxt;
    status_r <= status_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    mode_nxt   = mode_r;
    key_nxt    = key_r;
    hnd_nxt    = hnd_r;
    occ_nxt    = occ_r;
    idx_nxt    = idx_r;
    cnt_nxt    = cnt_r;
    status_nxt = status_r;
    we         = 1'b0;
    re         = 1'b0;
    waddr      = idx_r;
    wdata      = rdata_b;
    req        = '0;

    unique case (state_r)
      dit_pkg::ST_IDLE: begin
        if (start) begin
          mode_nxt   = item.mode;
          key_nxt    = item.key_token;
          hnd_nxt    = item.handle;
          cnt_nxt    = '0;
          status_nxt = 1'b0;
          state_nxt  = dit_pkg::ST_SUM;
          unique case (item.mode)
            dit_pkg::MODE_ADD: begin
              if (occ_r < OCC_W'(TABLE_DEPTH)) begin
                we      = 1'b1;
                waddr   = IDX_W'(occ_r);
                wdata   = {item.key_token, item.handle};
                occ_nxt = occ_r + OCC_W'(1);
              end else begin
                status_nxt = 1'b1;
              end
            end
            dit_pkg::MODE_REMOVE, dit_pkg::MODE_INVAL: begin
              if (occ_r != '0) begin
                idx_nxt   = last_idx;
                state_nxt = dit_pkg::ST_RD;
              end
            end
            default: ;
          endcase
        end
      end
      dit_pkg::ST_RD: begin
        re        = 1'b1;
        state_nxt = dit_pkg::ST_CMP;
      end
      dit_pkg::ST_CMP: begin
        req.valid             = emit;
        req.data.stale_handle = rd_hnd;
        req.data.stale_valid  = 1'b1;
        if (!emit || take) begin
          if (match) begin
            we      = 1'b1;
            occ_nxt = occ_r - OCC_W'(1);
            if (mode_r == dit_pkg::MODE_REMOVE || emit) begin
              cnt_nxt = cnt_inc;
            end
          end
          if (idx_r == '0) begin
            state_nxt = dit_pkg::ST_SUM;
          end else begin
            idx_nxt   = idx_r - IDX_W'(1);
            state_nxt = dit_pkg::ST_RD;
          end
        end
      end
      dit_pkg::ST_SUM: begin
        req.valid            = 1'b1;
        req.data.match_count = cnt_r;
        req.data.status      = status_r;
        req.data.last        = 1'b1;
        if (take) begin
          state_nxt = dit_pkg::ST_IDLE;
        end
      end
      default: state_nxt = dit_pkg::ST_IDLE;
    endcase
  end

endmodule

FILE: rtl/dit_checker.sv
// Port checker for the dependency invalidation table, bound to the top level.
module dit_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_stall,
  input dit_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_stall,
  input dit_pkg::out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while previous item in flight");

  a_stale_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.stale_valid |-> !out_data.last && out_data.stale_handle != '0)
    else $error("bad stale result");

  a_status_on_summary: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status |-> out_data.last && out_data.match_count == '0)
    else $error("full status on non-summary result");

  a_count_on_summary: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |-> out_data.stale_valid && out_data.match_count == '0)
    else $error("non-final result without stale handle");

endmodule

bind dependency_invalidation_table dit_checker u_dit_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

FILE: bench/testbench.sv
// Testbench for dependency_invalidation_table: directed and random table operations.
module testbench;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int DEPTH = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 290;
  localparam int TAIL_CYCLES = 40;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  dit_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  dit_pkg::out_t out_data;

  logic [31:0] tbl_key [DEPTH];
  logic [15:0] tbl_hnd [DEPTH];
  int tbl_count = 0;
  dit_pkg::out_t awaited_results [$];

  int fail_count = 0;
  int cycle_count = 0;
  int burst_left = 0;
  int sent_items = 0;
  int stall_mode = 0;

  dependency_invalidation_table #(.TABLE_DEPTH(DEPTH)) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still awaited", $time, awaited_results.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver stall pattern: switches at random among no stall, sparse or dense random stalls and a periodic stall
  always @(posedge clk) begin
    if (cycle_count % 50 == 0) begin
      stall_mode <= $urandom_range(0, 3);
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 9) < 7);
      default: out_stall <= (cycle_count % 3 == 0);
    endcase
  end

  function automatic void push_result(logic [15:0] h, logic v, int cnt, logic st, logic lst);
    dit_pkg::out_t r;
    r.stale_handle = h;
    r.stale_valid = v;
    r.match_count = (cnt > dit_pkg::COUNT_MAX) ? dit_pkg::COUNT_MAX : cnt[dit_pkg::CNT_W-1:0];
    r.status = st;
    r.last = lst;
    awaited_results.insert(awaited_results.size(), r);
  endfunction

  function automatic void drop_slot(int s);
    tbl_key[s] = tbl_key[tbl_count-1];
    tbl_hnd[s] = tbl_hnd[tbl_count-1];
    tbl_count--;
  endfunction

  function automatic void apply_table_op(dit_pkg::in_t item);
    int cnt;
    cnt = 0;
    case (item.mode)
      dit_pkg::MODE_ADD: begin
        if (tbl_count < DEPTH) begin
          tbl_key[tbl_count] = item.key_token;
          tbl_hnd[tbl_count] = item.handle;
          tbl_count++;
          push_result('0, 1'b0, 0, 1'b0, 1'b1);
        end else begin
          push_result('0, 1'b0, 0, 1'b1, 1'b1);
        end
      end
      dit_pkg::MODE_REMOVE: begin
        for (int i = tbl_count - 1; i >= 0; i--) begin
          if (tbl_hnd[i] == item.handle) begin
            drop_slot(i);
            cnt++;
          end
        end
        push_result('0, 1'b0, cnt, 1'b0, 1'b1);
      end
      dit_pkg::MODE_INVAL: begin
        for (int i = tbl_count - 1; i >= 0; i--) begin
          if (tbl_key[i] == item.key_token) begin
            if (tbl_hnd[i] != '0) begin
              push_result(tbl_hnd[i], 1'b1, 0, 1'b0, 1'b0);
              cnt++;
            end
            drop_slot(i);
          end
        end
        push_result('0, 1'b0, cnt, 1'b0, 1'b1);
      end
      default: push_result('0, 1'b0, 0, 1'b0, 1'b1);
    endcase
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    dit_pkg::out_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: result with none awaited, expected nothing, actual %h", $time, out_data);
        fail_count++;
      end else begin
        exp_r = awaited_results.pop_front();
        check_field("stale_handle", 32'(exp_r.stale_handle), 32'(out_data.stale_handle));
        check_field("stale_valid", 32'(exp_r.stale_valid), 32'(out_data.stale_valid));
        check_field("match_count", 32'(exp_r.match_count), 32'(out_data.match_count));
        check_field("status", 32'(exp_r.status), 32'(out_data.status));
        check_field("last", 32'(exp_r.last), 32'(out_data.last));
      end
    end
  end

  function automatic dit_pkg::in_t make_item(logic [1:0] m, logic [31:0] k, logic [15:0] h);
    dit_pkg::in_t it;
    it.mode = m;
    it.key_token = k;
    it.handle = h;
    return it;
  endfunction

  function automatic logic [31:0] pick_key();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'h0;
    if (r == 1) return 32'hFFFF_FFFF;
    if (r < 7) return 32'hC0DE_0000 | $urandom_range(0, 3);
    return $urandom();
  endfunction

  function automatic logic [15:0] pick_handle();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h0;
    if (r == 1) return 16'hFFFF;
    if (r < 7) return 16'($urandom_range(1, 6));
    return 16'($urandom());
  endfunction

  task automatic send_item(dit_pkg::in_t item);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 30);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    apply_table_op(item);
    sent_items++;
    burst_left--;
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic test_fill_to_overflow();
    logic [31:0] k;
    logic [15:0] h;
    for (int i = 0; i < DEPTH; i++) begin
      k = (i < 12) ? 32'hFFFF_FFFF : 32'h0;
      if (i == 3 || i == 13) h = 16'h0;
      else if (i == 5 || i == 14) h = 16'hFFFF;
      else h = 16'(i + 1);
      send_item(make_item(dit_pkg::MODE_ADD, k, h));
    end
    send_item(make_item(dit_pkg::MODE_ADD, 32'h0, 16'hFFFF));
  endtask

  task automatic test_invalidate_key();
    send_item(make_item(dit_pkg::MODE_INVAL, 32'hFFFF_FFFF, 16'h1234));
    send_item(make_item(dit_pkg::MODE_INVAL, 32'h0000_0001, 16'hFFFF));
  endtask

  task automatic test_remove_by_handle();
    send_item(make_item(dit_pkg::MODE_REMOVE, 32'hDEAD_BEEF, 16'h0));
    send_item(make_item(dit_pkg::MODE_REMOVE, 32'h0, 16'hFFFF));
  endtask

  task automatic test_unused_mode();
    send_item(make_item(MODE_UNUSED, 32'hFFFF_FFFF, 16'hFFFF));
  endtask

  task automatic run_mixed_ops(int n);
    int r;
    logic [31:0] k;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        send_item(make_item(dit_pkg::MODE_ADD, pick_key(), pick_handle()));
      end else if (r < 65) begin
        send_item(make_item(dit_pkg::MODE_REMOVE, $urandom(), pick_handle()));
      end else if (r < 95) begin
        if (tbl_count > 0 && $urandom_range(0, 9) < 6) begin
          k = tbl_key[$urandom_range(0, tbl_count-1)];
        end else begin
          k = pick_key();
        end
        send_item(make_item(dit_pkg::MODE_INVAL, k, 16'($urandom())));
      end else begin
        send_item(make_item(MODE_UNUSED, $urandom(), 16'($urandom())));
      end
    end
  endtask

  // empty the table, fill it with one key, overflow, then invalidate that key
  task automatic run_fill_and_flush();
    logic [31:0] k;
    while (tbl_count > 0) begin
      send_item(make_item(dit_pkg::MODE_INVAL, tbl_key[tbl_count-1], 16'($urandom())));
    end
    k = pick_key();
    for (int i = 0; i <= DEPTH; i++) begin
      send_item(make_item(dit_pkg::MODE_ADD, k, 16'($urandom_range(1, 16'hFFFF))));
    end
    send_item(make_item(dit_pkg::MODE_INVAL, k, 16'($urandom())));
  endtask

  task automatic test_random_traffic();
    int start;
    int episode;
    int kind;
    start = sent_items;
    episode = 0;
    while (sent_items - start < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        run_mixed_ops($urandom_range(8, 24));
      end else if (kind < 8) begin
        run_fill_and_flush();
      end else if (kind == 8) begin
        for (int i = $urandom_range(3, 6); i > 0; i--) begin
          send_item(make_item(2'($urandom_range(0, 3)), $urandom(), 16'($urandom())));
        end
      end else begin
        for (int i = $urandom_range(2, 5); i > 0; i--) begin
          send_item(make_item(dit_pkg::MODE_REMOVE, $urandom(), pick_handle()));
        end
      end
      episode++;
      if (episode == 6) wait_for_drain();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_fill_to_overflow();
    test_invalidate_key();
    test_remove_by_handle();
    test_unused_mode();
    wait_for_drain();
    test_random_traffic();
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/dit_pkg.sv
rtl/dit_ram.sv
rtl/dit_scan.sv
rtl/dependency_invalidation_table.sv
rtl/dit_checker.sv
bench/testbench.sv
